// File: hdl/m4vt_pkg.sv
package m4vt_pkg;

   localparam int NumComps = 4;
   localparam int VecWidth = 16;
   localparam int ProdWidth = 2 * VecWidth;
   localparam int SumWidth = ProdWidth + 3;
   localparam int CsrDataWidth = NumComps * VecWidth;

   typedef enum logic [1:0] {
      CSR_MATRIX_ROW0,
      CSR_MATRIX_ROW1,
      CSR_MATRIX_ROW2,
      CSR_MATRIX_ROW3
   } csr_index_type;

   typedef struct packed {
      logic signed [VecWidth-1:0] vec_x;
      logic signed [VecWidth-1:0] vec_y;
      logic signed [VecWidth-1:0] vec_z;
      logic signed [VecWidth-1:0] vec_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [VecWidth-1:0] out_x;
      logic signed [VecWidth-1:0] out_y;
      logic signed [VecWidth-1:0] out_z;
      logic signed [VecWidth-1:0] out_w;
      logic [NumComps-1:0]        saturation_mask;
   } rsp_payload_type;

endpackage

// File: hdl/m4vt_stream_if.sv
interface m4vt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/m4vt_csr_regs.sv
module m4vt_csr_regs #(
   parameter int DIMENSION = 4,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  m4vt_pkg::csr_index_type              csr_index,
   input  logic [m4vt_pkg::CsrDataWidth-1:0]    csr_data,
   output logic [m4vt_pkg::CsrDataWidth-1:0]    matrix [DIMENSION]
);

   logic [m4vt_pkg::NumComps-1:0] row_sel;
   logic [m4vt_pkg::CsrDataWidth-1:0] row_ff [DIMENSION];

   always_comb begin
      row_sel = '0;
      unique case (csr_index)
         m4vt_pkg::CSR_MATRIX_ROW0: row_sel[0] = csr_write;
         m4vt_pkg::CSR_MATRIX_ROW1: row_sel[1] = csr_write;
         m4vt_pkg::CSR_MATRIX_ROW2: row_sel[2] = csr_write;
         m4vt_pkg::CSR_MATRIX_ROW3: row_sel[3] = csr_write;
         default: row_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < DIMENSION; r++) begin
         if (reset) begin
            row_ff[r] <= m4vt_pkg::CsrDataWidth'(64'd1 << COEF_FRAC_BITS)
                         << (m4vt_pkg::VecWidth * r);
         end else if (row_sel[r]) begin
            row_ff[r] <= csr_data;
         end
      end
   end

   assign matrix = row_ff;

endmodule

// File: hdl/m4vt_mul_stage.sv
module m4vt_mul_stage #(
   parameter int DIMENSION = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  m4vt_pkg::req_payload_type              vec,
   input  logic [m4vt_pkg::CsrDataWidth-1:0]      matrix [DIMENSION],
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [m4vt_pkg::ProdWidth-1:0]  prod [DIMENSION][DIMENSION]
);

   logic valid_ff;
   logic load;
   logic signed [m4vt_pkg::VecWidth-1:0] vec_all [m4vt_pkg::NumComps];
   logic signed [m4vt_pkg::VecWidth-1:0] coef;
   logic signed [m4vt_pkg::ProdWidth-1:0] prod_in [DIMENSION][DIMENSION];
   logic signed [m4vt_pkg::ProdWidth-1:0] prod_ff [DIMENSION][DIMENSION];

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      coef = '0;
      vec_all[0] = vec.vec_x;
      vec_all[1] = vec.vec_y;
      vec_all[2] = vec.vec_z;
      vec_all[3] = vec.vec_w;
      for (int r = 0; r < DIMENSION; r++) begin
         for (int k = 0; k < DIMENSION; k++) begin
            coef = $signed(matrix[r][k * m4vt_pkg::VecWidth +: m4vt_pkg::VecWidth]);
            prod_in[r][k] = coef * vec_all[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod = prod_ff;

endmodule

// File: hdl/m4vt_sum_stage.sv
module m4vt_sum_stage #(
   parameter int DIMENSION = 4,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [m4vt_pkg::ProdWidth-1:0]  prod [DIMENSION][DIMENSION],
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output m4vt_pkg::rsp_payload_type              result
);

   localparam int SW = m4vt_pkg::SumWidth;
   localparam logic signed [SW-1:0] RoundBias =
      (COEF_FRAC_BITS > 0) ? (SW'(1) <<< ((COEF_FRAC_BITS > 0) ? COEF_FRAC_BITS - 1 : 0))
                           : '0;
   localparam logic signed [SW-1:0] SatMax = SW'((1 << (m4vt_pkg::VecWidth - 1)) - 1);
   localparam logic signed [SW-1:0] SatMin = -SW'(1 << (m4vt_pkg::VecWidth - 1));

   logic valid_ff;
   logic load;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] shifted;
   logic signed [m4vt_pkg::VecWidth-1:0] comp [m4vt_pkg::NumComps];
   logic [m4vt_pkg::NumComps-1:0] mask;
   m4vt_pkg::rsp_payload_type result_in;
   m4vt_pkg::rsp_payload_type result_ff;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready;

   always_comb begin
      sum = '0;
      shifted = '0;
      mask = '0;
      for (int r = 0; r < m4vt_pkg::NumComps; r++) begin
         comp[r] = '0;
      end
      for (int r = 0; r < DIMENSION; r++) begin
         sum = RoundBias;
         for (int k = 0; k < DIMENSION; k++) begin
            sum = sum + SW'(prod[r][k]);
         end
         shifted = sum >>> COEF_FRAC_BITS;
         if (shifted > SatMax) begin
            comp[r] = SatMax[m4vt_pkg::VecWidth-1:0];
            mask[r] = 1'b1;
         end else if (shifted < SatMin) begin
            comp[r] = SatMin[m4vt_pkg::VecWidth-1:0];
            mask[r] = 1'b1;
         end else begin
            comp[r] = shifted[m4vt_pkg::VecWidth-1:0];
         end
      end
      result_in.out_x = comp[0];
      result_in.out_y = comp[1];
      result_in.out_z = comp[2];
      result_in.out_w = comp[3];
      result_in.saturation_mask = mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign result = result_ff;

endmodule

// File: hdl/matrix4_vector_transform.sv
// Channel  Direction  Beat contents
// req_bus  in         vec_x, vec_y, vec_z, vec_w (signed 16 bits each)
// rsp_bus  out        out_x, out_y, out_z, out_w, saturation_mask
// csr      in         csr_write, csr_index (matrix row), csr_data (64 bits)
//
// One vector is accepted per cycle unless rsp_bus stalls the pipeline; its result beat
// passes through the products register and then the result register.
// Reset clears both stage valid flags and loads the identity matrix.
// A stalled rsp_bus lets two beats queue in the pipeline before req_bus.ready drops.
module matrix4_vector_transform #(
   parameter int DIMENSION = 4,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   m4vt_stream_if.sink                         req_bus,
   m4vt_stream_if.source                       rsp_bus,
   input  logic                                csr_write,
   input  m4vt_pkg::csr_index_type             csr_index,
   input  logic [m4vt_pkg::CsrDataWidth-1:0]   csr_data
);

   logic [m4vt_pkg::CsrDataWidth-1:0] matrix [DIMENSION];
   logic signed [m4vt_pkg::ProdWidth-1:0] prod [DIMENSION][DIMENSION];
   logic prod_valid;
   logic prod_ready;
   m4vt_pkg::rsp_payload_type result;

   m4vt_csr_regs #(
      .DIMENSION(DIMENSION),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_csr_regs (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .matrix(matrix)
   );

   m4vt_mul_stage #(
      .DIMENSION(DIMENSION)
   ) u_mul_stage (
      .clock(clock),
      .reset(reset),
      .in_valid(req_bus.valid),
      .in_ready(req_bus.ready),
      .vec(req_bus.payload),
      .matrix(matrix),
      .out_valid(prod_valid),
      .out_ready(prod_ready),
      .prod(prod)
   );

   m4vt_sum_stage #(
      .DIMENSION(DIMENSION),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_sum_stage (
      .clock(clock),
      .reset(reset),
      .in_valid(prod_valid),
      .in_ready(prod_ready),
      .prod(prod),
      .out_valid(rsp_bus.valid),
      .out_ready(rsp_bus.ready),
      .result(result)
   );

   assign rsp_bus.payload = result;

   a_backpressure_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("input stalled while the result stage could move");

   a_mask_x_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && result.saturation_mask[0] |->
         result.out_x == 16'sh7FFF || result.out_x == -16'sh8000)
      else $error("saturation flag on x without a clipped value");

   a_unused_rows_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (result.saturation_mask >> DIMENSION) == '0)
      else $error("saturation flag on an unused row");

   a_row0_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == m4vt_pkg::CSR_MATRIX_ROW0 |=> matrix[0] == $past(csr_data))
      else $error("matrix row 0 write was lost");

endmodule

// File: bench/matrix_transform_checker.sv
`timescale 1ns / 1ps
module matrix_transform_checker #(
   parameter int DIMENSION = 4,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  m4vt_pkg::req_payload_type           req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  m4vt_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_write,
   input  m4vt_pkg::csr_index_type             csr_index,
   input  logic [m4vt_pkg::CsrDataWidth-1:0]   csr_data,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  vector_count,
   output int                                  clipped_count
);

   localparam longint OutMax = (longint'(1) <<< (m4vt_pkg::VecWidth - 1)) - 1;
   localparam longint OutMin = -(longint'(1) <<< (m4vt_pkg::VecWidth - 1));
   localparam longint RoundBias =
      (COEF_FRAC_BITS > 0) ? (longint'(1) <<< (COEF_FRAC_BITS - 1)) : 0;

   logic [m4vt_pkg::CsrDataWidth-1:0] matrix_rows [m4vt_pkg::NumComps];
   m4vt_pkg::rsp_payload_type         transformed_q [$];

   function automatic m4vt_pkg::rsp_payload_type transform_vector(
      input m4vt_pkg::req_payload_type v);
      logic signed [m4vt_pkg::VecWidth-1:0] comp [m4vt_pkg::NumComps];
      logic signed [m4vt_pkg::VecWidth-1:0] result [m4vt_pkg::NumComps];
      logic signed [m4vt_pkg::VecWidth-1:0] coef;
      logic [m4vt_pkg::NumComps-1:0]        clipped;
      m4vt_pkg::rsp_payload_type            predicted;
      longint                               acc;
      comp[0] = v.vec_x;
      comp[1] = v.vec_y;
      comp[2] = v.vec_z;
      comp[3] = v.vec_w;
      clipped = '0;
      for (int r = 0; r < m4vt_pkg::NumComps; r++) begin
         result[r] = '0;
         if (r < DIMENSION) begin
            acc = 0;
            for (int k = 0; k < DIMENSION; k++) begin
               coef = matrix_rows[r][m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth];
               acc += longint'(coef) * longint'(comp[k]);
            end
            acc = (acc + RoundBias) >>> COEF_FRAC_BITS;
            if (acc > OutMax) begin
               result[r] = OutMax[m4vt_pkg::VecWidth-1:0];
               clipped[r] = 1'b1;
            end else if (acc < OutMin) begin
               result[r] = OutMin[m4vt_pkg::VecWidth-1:0];
               clipped[r] = 1'b1;
            end else begin
               result[r] = acc[m4vt_pkg::VecWidth-1:0];
            end
         end
      end
      predicted.out_x = result[0];
      predicted.out_y = result[1];
      predicted.out_z = result[2];
      predicted.out_w = result[3];
      predicted.saturation_mask = clipped;
      return predicted;
   endfunction

   task automatic compare_field(input string field, input int predicted, input int actual);
      if (predicted !== actual) begin
         $error("%s mismatch: expected %0d, actual %0d", field, predicted, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      m4vt_pkg::rsp_payload_type predicted;
      if (reset) begin
         for (int r = 0; r < m4vt_pkg::NumComps; r++) begin
            matrix_rows[r] = (m4vt_pkg::CsrDataWidth'(1) << COEF_FRAC_BITS)
                             << (m4vt_pkg::VecWidth * r);
         end
         transformed_q.delete();
         fail_count = 0;
         vector_count = 0;
         clipped_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (transformed_q.size() == 0) begin
               $error("result beat with no vector outstanding");
               fail_count++;
            end else begin
               predicted = transformed_q.pop_front();
               compare_field("out_x", int'(predicted.out_x), int'(rsp_payload.out_x));
               compare_field("out_y", int'(predicted.out_y), int'(rsp_payload.out_y));
               compare_field("out_z", int'(predicted.out_z), int'(rsp_payload.out_z));
               compare_field("out_w", int'(predicted.out_w), int'(rsp_payload.out_w));
               compare_field("saturation_mask", int'(predicted.saturation_mask),
                             int'(rsp_payload.saturation_mask));
               vector_count++;
               clipped_count += $countones(predicted.saturation_mask);
            end
         end
         if (req_valid && req_ready) begin
            transformed_q.push_back(transform_vector(req_payload));
         end
         if (csr_write) begin
            matrix_rows[csr_index] = csr_data;
         end
      end
      pending_count = transformed_q.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int Dimension = 4;
   localparam int FracBits = 12;
   localparam int CycleLimit = 400000;
   localparam int PhaseVectors = 190;

   logic                              clock;
   logic                              reset;
   logic                              csr_write;
   m4vt_pkg::csr_index_type           csr_index;
   logic [m4vt_pkg::CsrDataWidth-1:0] csr_data;

   int fail_count;
   int pending_count;
   int vector_count;
   int clipped_count;
   int cycle_count = 0;
   int matrix_loads = 0;
   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;

   m4vt_stream_if #(.payload_type(m4vt_pkg::req_payload_type)) req_bus ();
   m4vt_stream_if #(.payload_type(m4vt_pkg::rsp_payload_type)) rsp_bus ();

   matrix4_vector_transform #(
      .DIMENSION(Dimension),
      .COEF_FRAC_BITS(FracBits)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   matrix_transform_checker #(
      .DIMENSION(Dimension),
      .COEF_FRAC_BITS(FracBits)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .req_payload(req_bus.payload),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .rsp_payload(rsp_bus.payload),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .vector_count(vector_count),
      .clipped_count(clipped_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("matrix4_vector_transform test failed");
         $finish;
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_vector(input logic [m4vt_pkg::VecWidth-1:0] x, y, z, w);
      m4vt_pkg::req_payload_type v;
      v.vec_x = x;
      v.vec_y = y;
      v.vec_z = z;
      v.vec_w = w;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= v;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_row(input m4vt_pkg::csr_index_type idx,
                            input logic [m4vt_pkg::CsrDataWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
   endtask

   task automatic load_matrix(input logic [m4vt_pkg::CsrDataWidth-1:0] r0, r1, r2, r3);
      write_row(m4vt_pkg::CSR_MATRIX_ROW0, r0);
      write_row(m4vt_pkg::CSR_MATRIX_ROW1, r1);
      write_row(m4vt_pkg::CSR_MATRIX_ROW2, r2);
      write_row(m4vt_pkg::CSR_MATRIX_ROW3, r3);
      csr_write <= 1'b0;
      matrix_loads++;
   endtask

   function automatic logic [m4vt_pkg::VecWidth-1:0] random_component();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 31)) - 16);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Affine rows keep the w component untouched, mode 2 favors clipping.
   function automatic logic [m4vt_pkg::CsrDataWidth-1:0] random_row(input int mode,
                                                                    input int r);
      logic [m4vt_pkg::CsrDataWidth-1:0] row;
      for (int k = 0; k < m4vt_pkg::NumComps; k++) begin
         case (mode)
            1: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] =
                  16'(int'($urandom_range(0, 16384)) - 8192);
            2: case ($urandom_range(0, 3))
                  0: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] = 16'h7FFF;
                  1: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] = 16'h8000;
                  2: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] = 16'h1000;
                  default: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] =
                              16'($urandom_range(0, 65535));
               endcase
            3: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] =
                  16'(int'($urandom_range(0, 1024)) - 512);
            default: row[m4vt_pkg::VecWidth*k +: m4vt_pkg::VecWidth] =
                        16'($urandom_range(0, 65535));
         endcase
      end
      if (mode == 1 && r == m4vt_pkg::NumComps - 1) begin
         row = 64'h1000_0000_0000_0000;
      end
      return row;
   endfunction

   initial begin
      int mode;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = m4vt_pkg::CSR_MATRIX_ROW0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_vector(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_vector(16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000);
      send_vector(16'h5A5A, 16'hA5A5, 16'h1234, 16'hEDCB);
      drain_results();

      // Half-way ties in the first two rows, clipping both ways in the last two.
      load_matrix(64'h0000_0000_0000_0800, 64'h0000_0000_0000_F800,
                  64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000);
      send_vector(16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_vector(16'h0003, 16'h0000, 16'h0000, 16'h0000);
      send_vector(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_vector(16'hFFFD, 16'h0000, 16'h0000, 16'h0000);
      send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_vector(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      drain_results();

      load_matrix(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
      send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_vector(16'h0800, 16'h0400, 16'h0200, 16'h0200);
      drain_results();

      for (int phase = 0; phase < 8; phase++) begin
         sender_idles = (phase != 2) && (phase < 6);
         receiver_stalls = (phase != 3) && (phase < 6);
         mode = phase % 4;
         load_matrix(random_row(mode, 0), random_row(mode, 1),
                     random_row(mode, 2), random_row(mode, 3));
         repeat (PhaseVectors) begin
            send_vector(random_component(), random_component(),
                        random_component(), random_component());
         end
         drain_results();
      end

      repeat (10) @(negedge clock);
      $display("Checked %0d transformed vectors under %0d matrix loads.",
               vector_count, matrix_loads);
      $display("%0d output components were clipped by saturation.", clipped_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("matrix4_vector_transform test passed");
      end else begin
         $display("matrix4_vector_transform test failed");
      end
      $finish;
   end

endmodule
